/* design/oriented_box_overlap_test_core_defines.svh */
// ----------------------------------------------------------------------------
// oriented box overlap test: assertion macros
// shared property wrappers, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ORIENTED_BOX_OVERLAP_TEST_CORE_DEFINES_SVH
`define ORIENTED_BOX_OVERLAP_TEST_CORE_DEFINES_SVH

// same-cycle implication
`define OBBT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OBBT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/obbt_pkg.sv */
// ----------------------------------------------------------------------------
// obbt_pkg
// types, control word layout and microcode program of the box overlap test
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package obbt_pkg;

	// item modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TEST = 1'b1;

	// sequencer sizes
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] UCODE_LAST = 4'd12;
	localparam int AXIS_IDX_W = 2;
	localparam logic [AXIS_IDX_W-1:0] LAST_AXIS = 2'd3;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// multiplier operand a
	typedef enum logic [2:0] {
		A_DX,
		A_DY,
		A_O1X,
		A_O1Y,
		A_O2X,
		A_O2Y,
		A_L1,
		A_L2
	} a_sel_t;

	// multiplier operand b
	typedef enum logic [2:0] {
		B_AX,
		B_AY,
		B_P1LO,
		B_P1HI,
		B_P2LO,
		B_P2HI
	} b_sel_t;

	// accumulator action on the registered product
	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_ADD_SH,
		ACC_INIT
	} acc_op_t;

	// magnitude capture from the accumulator
	typedef enum logic [1:0] {
		LAT_NONE,
		LAT_DIST,
		LAT_P1,
		LAT_P2
	} lat_t;

	typedef struct packed {
		a_sel_t  a_sel;
		b_sel_t  b_sel;
		acc_op_t acc_op;
		lat_t    lat;
		logic    last;
	} ctrl_t;

	localparam ctrl_t CTRL_IDLE = '{A_DX, B_AX, ACC_HOLD, LAT_NONE, 1'b0};

	// one axis of the test; the product of a step is accumulated in the next
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t cw;
		begin
			unique case (pc)
				4'd0:  cw = '{A_DX,  B_AX,   ACC_HOLD,   LAT_NONE, 1'b0};
				4'd1:  cw = '{A_DY,  B_AY,   ACC_LOAD,   LAT_NONE, 1'b0};
				4'd2:  cw = '{A_O1X, B_AX,   ACC_ADD,    LAT_NONE, 1'b0};
				4'd3:  cw = '{A_O1Y, B_AY,   ACC_LOAD,   LAT_DIST, 1'b0};
				4'd4:  cw = '{A_O2X, B_AX,   ACC_ADD,    LAT_NONE, 1'b0};
				4'd5:  cw = '{A_O2Y, B_AY,   ACC_LOAD,   LAT_P1,   1'b0};
				4'd6:  cw = '{A_DX,  B_AX,   ACC_ADD,    LAT_NONE, 1'b0};
				4'd7:  cw = '{A_L1,  B_P1LO, ACC_INIT,   LAT_P2,   1'b0};
				4'd8:  cw = '{A_L1,  B_P1HI, ACC_ADD,    LAT_NONE, 1'b0};
				4'd9:  cw = '{A_L2,  B_P2LO, ACC_ADD_SH, LAT_NONE, 1'b0};
				4'd10: cw = '{A_L2,  B_P2HI, ACC_ADD,    LAT_NONE, 1'b0};
				4'd11: cw = '{A_DX,  B_AX,   ACC_ADD_SH, LAT_NONE, 1'b0};
				4'd12: cw = '{A_DX,  B_AX,   ACC_HOLD,   LAT_NONE, 1'b1};
				default: cw = CTRL_IDLE;
			endcase
			return cw;
		end
	endfunction

endpackage

/* design/oriented_box_overlap_test_core.sv */
// ----------------------------------------------------------------------------
// oriented_box_overlap_test_core
// separating-axis overlap test of two 2d oriented boxes, microcoded
//
// channel   handshake               payload
// -------   ---------------------   ---------------------------------------
// item in   start high, busy low    mode, center_x/y, axis1_x/y, axis2_x/y,
//                                   half_len1, half_len2
// result    done strobe, one cycle  overlap
//
// a load beat gives no result
// a test beat keeps busy high through the program for each of four axes,
// stopping when an axis separates; one shared multiplier paced by the program
// the result strobe comes in the cycle after the last step, busy already low
// reset clears the reference box to all zeros and the sequencer to idle
// the receiver cannot stall; each result is shown for exactly one cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "oriented_box_overlap_test_core_defines.svh"

module oriented_box_overlap_test_core
	import obbt_pkg::*;
#(
	parameter int COORD_WIDTH = 24,
	parameter int AXIS_WIDTH  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          mode,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	input  logic signed [AXIS_WIDTH-1:0]  axis1_x,
	input  logic signed [AXIS_WIDTH-1:0]  axis1_y,
	input  logic signed [AXIS_WIDTH-1:0]  axis2_x,
	input  logic signed [AXIS_WIDTH-1:0]  axis2_y,
	input  logic        [COORD_WIDTH-2:0] half_len1,
	input  logic        [COORD_WIDTH-2:0] half_len2,
	output logic                          done,
	output logic                          overlap
);

	state_t state_q, state_d;
	logic [PC_W-1:0]       pc_q, pc_d;
	logic [AXIS_IDX_W-1:0] axis_q, axis_d;
	logic                  done_q, done_d;
	logic                  overlap_q, overlap_d;
	ctrl_t                 ctrl;
	logic                  acc_neg;
	logic                  take;

	// reference box
	logic signed [COORD_WIDTH-1:0] ref_cx_q, ref_cy_q;
	logic signed [AXIS_WIDTH-1:0]  ref_a1x_q, ref_a1y_q, ref_a2x_q, ref_a2y_q;
	logic        [COORD_WIDTH-2:0] ref_h1_q, ref_h2_q;

	// test box and center offset
	logic signed [AXIS_WIDTH-1:0]  tst_a1x_q, tst_a1y_q, tst_a2x_q, tst_a2y_q;
	logic        [COORD_WIDTH-2:0] tst_h1_q, tst_h2_q;
	logic signed [COORD_WIDTH:0]   dx_q, dy_q;

	// per-axis operands
	logic signed [AXIS_WIDTH-1:0]  ax, ay, o1x, o1y, o2x, o2y;
	logic        [COORD_WIDTH-2:0] r, l1, l2;

	assign take    = start && (state_q == ST_IDLE);
	assign busy    = (state_q == ST_RUN);
	assign done    = done_q;
	assign overlap = overlap_q;
	assign ctrl    = busy ? ucode(pc_q) : CTRL_IDLE;

	// reference box store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_cx_q  <= '0;
			ref_cy_q  <= '0;
			ref_a1x_q <= '0;
			ref_a1y_q <= '0;
			ref_a2x_q <= '0;
			ref_a2y_q <= '0;
			ref_h1_q  <= '0;
			ref_h2_q  <= '0;
		end else if (take && mode == MODE_LOAD) begin
			ref_cx_q  <= center_x;
			ref_cy_q  <= center_y;
			ref_a1x_q <= axis1_x;
			ref_a1y_q <= axis1_y;
			ref_a2x_q <= axis2_x;
			ref_a2y_q <= axis2_y;
			ref_h1_q  <= half_len1;
			ref_h2_q  <= half_len2;
		end
	end

	// test box capture
	always_ff @(posedge clk) begin
		if (take && mode == MODE_TEST) begin
			tst_a1x_q <= axis1_x;
			tst_a1y_q <= axis1_y;
			tst_a2x_q <= axis2_x;
			tst_a2y_q <= axis2_y;
			tst_h1_q  <= half_len1;
			tst_h2_q  <= half_len2;
			dx_q      <= (COORD_WIDTH+1)'(center_x) - (COORD_WIDTH+1)'(ref_cx_q);
			dy_q      <= (COORD_WIDTH+1)'(center_y) - (COORD_WIDTH+1)'(ref_cy_q);
		end
	end

	// axis under test and the other box
	always_comb begin
		unique case (axis_q)
			2'd0: begin
				ax = tst_a1x_q; ay = tst_a1y_q; r = tst_h1_q;
				o1x = ref_a1x_q; o1y = ref_a1y_q; l1 = ref_h1_q;
				o2x = ref_a2x_q; o2y = ref_a2y_q; l2 = ref_h2_q;
			end
			2'd1: begin
				ax = tst_a2x_q; ay = tst_a2y_q; r = tst_h2_q;
				o1x = ref_a1x_q; o1y = ref_a1y_q; l1 = ref_h1_q;
				o2x = ref_a2x_q; o2y = ref_a2y_q; l2 = ref_h2_q;
			end
			2'd2: begin
				ax = ref_a1x_q; ay = ref_a1y_q; r = ref_h1_q;
				o1x = tst_a1x_q; o1y = tst_a1y_q; l1 = tst_h1_q;
				o2x = tst_a2x_q; o2y = tst_a2y_q; l2 = tst_h2_q;
			end
			default: begin
				ax = ref_a2x_q; ay = ref_a2y_q; r = ref_h2_q;
				o1x = tst_a1x_q; o1y = tst_a1y_q; l1 = tst_h1_q;
				o2x = tst_a2x_q; o2y = tst_a2y_q; l2 = tst_h2_q;
			end
		endcase
	end

	obbt_datapath #(
		.COORD_WIDTH(COORD_WIDTH),
		.AXIS_WIDTH (AXIS_WIDTH)
	) u_datapath (
		.clk    (clk),
		.ctrl   (ctrl),
		.dx     (dx_q),
		.dy     (dy_q),
		.ax     (ax),
		.ay     (ay),
		.o1x    (o1x),
		.o1y    (o1y),
		.o2x    (o2x),
		.o2y    (o2y),
		.r      (r),
		.l1     (l1),
		.l2     (l2),
		.acc_neg(acc_neg)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pc_q      <= '0;
			axis_q    <= '0;
			done_q    <= 1'b0;
			overlap_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			pc_q      <= pc_d;
			axis_q    <= axis_d;
			done_q    <= done_d;
			overlap_q <= overlap_d;
		end
	end

	// step counter, axis loop and early exit on a separating axis
	always_comb begin
		state_d   = state_q;
		pc_d      = pc_q;
		axis_d    = axis_q;
		done_d    = 1'b0;
		overlap_d = overlap_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && mode == MODE_TEST) begin
					state_d = ST_RUN;
					pc_d    = '0;
					axis_d  = '0;
				end
			end
			ST_RUN: begin
				priority if (!ctrl.last) begin
					pc_d = pc_q + 1'b1;
				end else if (acc_neg) begin
					state_d   = ST_IDLE;
					done_d    = 1'b1;
					overlap_d = 1'b0;
				end else if (axis_q == LAST_AXIS) begin
					state_d   = ST_IDLE;
					done_d    = 1'b1;
					overlap_d = 1'b1;
				end else begin
					axis_d = axis_q + 1'b1;
					pc_d   = '0;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// checks
	`OBBT_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")
	`OBBT_ASSERT_NEXT(a_load_silent, start && !busy && mode == MODE_LOAD, !done && !busy,
		"load beat gave a result")
	`OBBT_ASSERT_NEXT(a_test_runs, start && !busy && mode == MODE_TEST, busy,
		"test beat did not start the sequencer")
	`OBBT_ASSERT_NOW(a_pc_range, busy, pc_q <= UCODE_LAST, "step counter past program end")

endmodule

/* design/obbt_datapath.sv */
// ----------------------------------------------------------------------------
// obbt_datapath
// shared multiplier, wide accumulator and magnitude registers for one axis
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obbt_datapath
	import obbt_pkg::*;
#(
	parameter int COORD_WIDTH = 24,
	parameter int AXIS_WIDTH  = 16
) (
	input  logic                          clk,
	input  ctrl_t                         ctrl,
	input  logic signed [COORD_WIDTH:0]   dx,
	input  logic signed [COORD_WIDTH:0]   dy,
	input  logic signed [AXIS_WIDTH-1:0]  ax,
	input  logic signed [AXIS_WIDTH-1:0]  ay,
	input  logic signed [AXIS_WIDTH-1:0]  o1x,
	input  logic signed [AXIS_WIDTH-1:0]  o1y,
	input  logic signed [AXIS_WIDTH-1:0]  o2x,
	input  logic signed [AXIS_WIDTH-1:0]  o2y,
	input  logic        [COORD_WIDTH-2:0] r,
	input  logic        [COORD_WIDTH-2:0] l1,
	input  logic        [COORD_WIDTH-2:0] l2,
	output logic                          acc_neg
);

	localparam int F    = AXIS_WIDTH - 2;
	localparam int MA   = (COORD_WIDTH + 1 > AXIS_WIDTH + 1) ? COORD_WIDTH + 1 : AXIS_WIDTH + 1;
	localparam int BW   = AXIS_WIDTH + 1;
	localparam int PW   = MA + BW;
	localparam int ACCW = 2 * AXIS_WIDTH + COORD_WIDTH + 3;
	localparam int DW   = COORD_WIDTH + AXIS_WIDTH + 1;
	localparam int PMW  = 2 * AXIS_WIDTH;

	logic signed [MA-1:0] op_a;
	logic signed [BW-1:0] op_b;
	logic signed [PW-1:0] prod_q;
	logic [ACCW-1:0]      acc_q;
	logic [ACCW-1:0]      acc_abs;
	logic [ACCW-1:0]      prod_ext;
	logic [DW-1:0]        dist_q;
	logic [PMW-1:0]       p1_q;
	logic [PMW-1:0]       p2_q;

	// operand a select
	always_comb begin
		unique case (ctrl.a_sel)
			A_DX:    op_a = MA'(dx);
			A_DY:    op_a = MA'(dy);
			A_O1X:   op_a = MA'(o1x);
			A_O1Y:   op_a = MA'(o1y);
			A_O2X:   op_a = MA'(o2x);
			A_O2Y:   op_a = MA'(o2y);
			A_L1:    op_a = MA'(l1);
			A_L2:    op_a = MA'(l2);
			default: op_a = MA'(dx);
		endcase
	end

	// operand b select, projection magnitudes split in halves
	always_comb begin
		unique case (ctrl.b_sel)
			B_AX:    op_b = BW'(ax);
			B_AY:    op_b = BW'(ay);
			B_P1LO:  op_b = BW'(p1_q[AXIS_WIDTH-1:0]);
			B_P1HI:  op_b = BW'(p1_q[PMW-1:AXIS_WIDTH]);
			B_P2LO:  op_b = BW'(p2_q[AXIS_WIDTH-1:0]);
			B_P2HI:  op_b = BW'(p2_q[PMW-1:AXIS_WIDTH]);
			default: op_b = BW'(ax);
		endcase
	end

	// sign extension and magnitude of the accumulator
	assign prod_ext = {{(ACCW-PW){prod_q[PW-1]}}, prod_q};
	assign acc_abs  = acc_q[ACCW-1] ? (~acc_q + 1'b1) : acc_q;
	assign acc_neg  = acc_q[ACCW-1];

	// multiply into the product register, then accumulate the registered product
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		unique case (ctrl.acc_op)
			ACC_HOLD:   acc_q <= acc_q;
			ACC_LOAD:   acc_q <= prod_ext;
			ACC_ADD:    acc_q <= acc_q + prod_ext;
			ACC_ADD_SH: acc_q <= acc_q + (prod_ext << AXIS_WIDTH);
			ACC_INIT:   acc_q <= (ACCW'(r) << (2 * F)) - (ACCW'(dist_q) << F);
			default:    acc_q <= acc_q;
		endcase
	end

	// magnitude capture
	always_ff @(posedge clk) begin
		unique case (ctrl.lat)
			LAT_DIST: dist_q <= acc_abs[DW-1:0];
			LAT_P1:   p1_q   <= acc_abs[PMW-1:0];
			LAT_P2:   p2_q   <= acc_abs[PMW-1:0];
			LAT_NONE: ;
			default:  ;
		endcase
	end

endmodule

/* sim/obbt_checker.sv */
// ----------------------------------------------------------------------------
// obbt_checker
// watches the item and result channels of the box overlap test, keeps its
// own copy of the reference box, predicts the overlap flag of every test
// beat with exact wide arithmetic and compares it with each result strobe
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obbt_checker
	import obbt_pkg::*;
#(
	parameter int COORD_WIDTH = 24,
	parameter int AXIS_WIDTH  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          mode,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	input  logic signed [AXIS_WIDTH-1:0]  axis1_x,
	input  logic signed [AXIS_WIDTH-1:0]  axis1_y,
	input  logic signed [AXIS_WIDTH-1:0]  axis2_x,
	input  logic signed [AXIS_WIDTH-1:0]  axis2_y,
	input  logic        [COORD_WIDTH-2:0] half_len1,
	input  logic        [COORD_WIDTH-2:0] half_len2,
	input  logic                          done,
	input  logic                          overlap,
	output int                            fail_count,
	output int                            pending_results
);

	localparam int FRAC = AXIS_WIDTH - 2;

	typedef logic [127:0] wide_t;

	// stored reference box
	longint          box_cx, box_cy;
	longint          box_a1x, box_a1y, box_a2x, box_a2y;
	longint unsigned box_h1, box_h2;

	// overlap flags still owed by the block, oldest first
	logic overlap_owed[$];
	logic owed_flag;

	function automatic wide_t magnitude(input longint v);
		return (v < 0) ? wide_t'(-v) : wide_t'(v);
	endfunction

	// axis (ax, ay) splits the boxes; own half extent r, other box axes o1, o2
	function automatic logic axis_separates(
		input longint ax, input longint ay, input longint dx, input longint dy,
		input longint unsigned r,
		input longint o1x, input longint o1y, input longint unsigned l1,
		input longint o2x, input longint o2y, input longint unsigned l2
	);
		wide_t gap, p1, p2, reach;
		gap   = magnitude(dx * ax + dy * ay);
		p1    = magnitude(o1x * ax + o1y * ay);
		p2    = magnitude(o2x * ax + o2y * ay);
		reach = (wide_t'(r) << (2 * FRAC)) + p1 * wide_t'(l1) + p2 * wide_t'(l2);
		return (gap << FRAC) > reach;
	endfunction

	// overlap of the presented box against the stored box, four axes
	function automatic logic boxes_overlap(
		input longint cx, input longint cy,
		input longint a1x, input longint a1y, input longint a2x, input longint a2y,
		input longint unsigned h1, input longint unsigned h2
	);
		longint dx, dy;
		logic   split;
		dx = cx - box_cx;
		dy = cy - box_cy;
		split = axis_separates(a1x, a1y, dx, dy, h1,
				box_a1x, box_a1y, box_h1, box_a2x, box_a2y, box_h2)
			|| axis_separates(a2x, a2y, dx, dy, h2,
				box_a1x, box_a1y, box_h1, box_a2x, box_a2y, box_h2)
			|| axis_separates(box_a1x, box_a1y, dx, dy, box_h1,
				a1x, a1y, h1, a2x, a2y, h2)
			|| axis_separates(box_a2x, box_a2y, dx, dy, box_h2,
				a1x, a1y, h1, a2x, a2y, h2);
		return !split;
	endfunction

	// compare result strobes, then take in the beat of this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_cx  = 0;
			box_cy  = 0;
			box_a1x = 0;
			box_a1y = 0;
			box_a2x = 0;
			box_a2y = 0;
			box_h1  = 0;
			box_h2  = 0;
			overlap_owed.delete();
			fail_count      = 0;
			pending_results = 0;
		end else begin
			if (done) begin
				if (overlap_owed.size() == 0) begin
					$error("overlap: expected none, got %0d", overlap);
					fail_count++;
				end else begin
					owed_flag = overlap_owed.pop_front();
					if (overlap !== owed_flag) begin
						$error("overlap: expected %0d, got %0d", owed_flag, overlap);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				if (mode == MODE_LOAD) begin
					box_cx  = center_x;
					box_cy  = center_y;
					box_a1x = axis1_x;
					box_a1y = axis1_y;
					box_a2x = axis2_x;
					box_a2y = axis2_y;
					box_h1  = half_len1;
					box_h2  = half_len2;
				end else begin
					overlap_owed.push_back(boxes_overlap(center_x, center_y,
						axis1_x, axis1_y, axis2_x, axis2_y, half_len1, half_len2));
				end
			end
			pending_results = overlap_owed.size();
		end
	end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// drives the box overlap test with a directed set of boxes (reset box,
// touching and split boxes, extreme and degenerate axes) and then with
// rotated boxes placed around a reference box plus random noise beats;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import obbt_pkg::*;

	localparam int CW        = 24;
	localparam int AW        = 16;
	localparam int RAND_BEATS = 930;
	localparam int ONE       = 256;    // 1.0 at coordinate scale
	localparam int UNIT      = 16384;  // 1.0 at axis scale
	localparam int DIAG      = 11585;  // 0.7071 at axis scale

	typedef struct {
		logic                 mode;
		logic signed [CW-1:0] cx, cy;
		logic signed [AW-1:0] a1x, a1y, a2x, a2y;
		logic        [CW-2:0] h1, h2;
	} box_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 mode = MODE_LOAD;
	logic signed [CW-1:0] center_x = '0;
	logic signed [CW-1:0] center_y = '0;
	logic signed [AW-1:0] axis1_x = '0;
	logic signed [AW-1:0] axis1_y = '0;
	logic signed [AW-1:0] axis2_x = '0;
	logic signed [AW-1:0] axis2_y = '0;
	logic        [CW-2:0] half_len1 = '0;
	logic        [CW-2:0] half_len2 = '0;
	logic                 done;
	logic                 overlap;
	logic                 beat_taken;
	int                   fail_count;
	int                   pending_results;

	// rough placement of the current reference box, for shaping test beats
	int ref_cx, ref_cy, ref_reach;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	oriented_box_overlap_test_core #(
		.COORD_WIDTH(CW),
		.AXIS_WIDTH (AW)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.mode     (mode),
		.center_x (center_x),
		.center_y (center_y),
		.axis1_x  (axis1_x),
		.axis1_y  (axis1_y),
		.axis2_x  (axis2_x),
		.axis2_y  (axis2_y),
		.half_len1(half_len1),
		.half_len2(half_len2),
		.done     (done),
		.overlap  (overlap)
	);

	obbt_checker #(
		.COORD_WIDTH(CW),
		.AXIS_WIDTH (AW)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.center_x       (center_x),
		.center_y       (center_y),
		.axis1_x        (axis1_x),
		.axis1_y        (axis1_y),
		.axis2_x        (axis2_x),
		.axis2_y        (axis2_y),
		.half_len1      (half_len1),
		.half_len2      (half_len2),
		.done           (done),
		.overlap        (overlap),
		.fail_count     (fail_count),
		.pending_results(pending_results)
	);

	// beat accepted at the last rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_taken <= 1'b0;
		end else begin
			beat_taken <= start && !busy;
		end
	end

	function automatic box_beat_t make_beat(
		input logic m, input int cx, input int cy,
		input int a1x, input int a1y, input int a2x, input int a2y,
		input int h1, input int h2
	);
		box_beat_t b;
		b.mode = m;
		b.cx   = CW'(cx);
		b.cy   = CW'(cy);
		b.a1x  = AW'(a1x);
		b.a1y  = AW'(a1y);
		b.a2x  = AW'(a2x);
		b.a2y  = AW'(a2y);
		b.h1   = (CW-1)'(h1);
		b.h2   = (CW-1)'(h2);
		return b;
	endfunction

	// every bit of every field at random
	function automatic box_beat_t noise_beat();
		return make_beat($urandom_range(1, 0), $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom);
	endfunction

	// box with unit axes at a random angle
	function automatic box_beat_t rotated_box(
		input logic m, input int cx, input int cy, input int h1, input int h2
	);
		real ang;
		int  c, s;
		ang = $urandom_range(3599) * 3.14159265358979 / 1800.0;
		c   = int'(UNIT * $cos(ang));
		s   = int'(UNIT * $sin(ang));
		return make_beat(m, cx, cy, c, s, -s, c, h1, h2);
	endfunction

	// half extent: mostly small, now and then large
	function automatic int pick_half();
		if ($urandom_range(19) == 0) begin
			return $urandom_range(1 << 20);
		end
		return $urandom_range(16 * ONE);
	endfunction

	task automatic send_beat(input box_beat_t b);
		mode      = b.mode;
		center_x  = b.cx;
		center_y  = b.cy;
		axis1_x   = b.a1x;
		axis1_y   = b.a1y;
		axis2_x   = b.a2x;
		axis2_y   = b.a2y;
		half_len1 = b.h1;
		half_len2 = b.h2;
		start     = 1'b1;
		do @(negedge clk); while (!beat_taken);
	endtask

	// start low, with junk on mode, both centers, axis1_x, axis2_y and half_len1 meanwhile
	task automatic hold_off(input int n);
		box_beat_t junk;
		start = 1'b0;
		repeat (n) begin
			junk      = noise_beat();
			mode      = junk.mode;
			center_x  = junk.cx;
			center_y  = junk.cy;
			axis1_x   = junk.a1x;
			axis2_y   = junk.a2y;
			half_len1 = junk.h1;
			@(negedge clk);
		end
	endtask

	task automatic maybe_idle(input bit quiet);
		if (!quiet && $urandom_range(99) < 16) begin
			if ($urandom_range(3) == 0) begin
				hold_off($urandom_range(60, 7));
			end else begin
				hold_off($urandom_range(6, 1));
			end
		end
	endtask

	// run timeout
	initial begin
		#(5_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		box_beat_t b;
		int        pick, h1, h2, span;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// test against the reset box, centered and far off
		send_beat(make_beat(MODE_TEST, 0, 0, UNIT, 0, 0, UNIT, ONE, ONE));
		send_beat(make_beat(MODE_TEST, 16 * ONE, 0, UNIT, 0, 0, UNIT, ONE, ONE));
		// unit square at the origin, then touching and just apart
		send_beat(make_beat(MODE_LOAD, 0, 0, UNIT, 0, 0, UNIT, ONE, ONE));
		send_beat(make_beat(MODE_TEST, 2 * ONE, 0, UNIT, 0, 0, UNIT, ONE, ONE));
		send_beat(make_beat(MODE_TEST, 2 * ONE + 1, 0, UNIT, 0, 0, UNIT, ONE, ONE));
		send_beat(make_beat(MODE_TEST, 0, -2 * ONE, UNIT, 0, 0, UNIT, ONE, ONE));
		hold_off(3);
		send_beat(make_beat(MODE_TEST, 0, -2 * ONE - 1, UNIT, 0, 0, UNIT, ONE, ONE));
		// 45 degree box near a corner
		send_beat(make_beat(MODE_TEST, 600, 600, DIAG, DIAG, -DIAG, DIAG, ONE, ONE));
		send_beat(make_beat(MODE_TEST, 500, 0, DIAG, DIAG, -DIAG, DIAG, ONE, ONE));
		// degenerate axes: zero and longer than one
		send_beat(make_beat(MODE_TEST, 100000, 0, 0, 0, 0, 0, 0, 0));
		send_beat(make_beat(MODE_TEST, 3 * ONE, ONE, 32767, 0, 0, -32768, ONE, ONE));
		// field extremes
		send_beat(make_beat(MODE_TEST, 8388607, -8388608, 32767, -32768, -32768, 32767,
			8388607, 8388607));
		send_beat(make_beat(MODE_TEST, -8388608, 8388607, UNIT, -UNIT, -UNIT, UNIT, 0, 0));
		send_beat(make_beat(MODE_LOAD, -8388608, 8388607, -32768, -32768, 32767, 32767,
			8388607, 8388607));
		send_beat(make_beat(MODE_TEST, 8388607, -8388608, -32768, 32767, 32767, -32768,
			8388607, 8388607));
		send_beat(make_beat(MODE_TEST, 8388607, -8388608, -32768, 32767, 32767, -32768,
			0, 0));
		// all-zero box against an all-zero reference touches
		send_beat(make_beat(MODE_LOAD, 0, 0, 0, 0, 0, 0, 0, 0));
		send_beat(make_beat(MODE_TEST, 0, 0, 0, 0, 0, 0, 0, 0));
		send_beat(make_beat(MODE_TEST, 1, -1, UNIT, 0, 0, UNIT, 0, 0));
		// identical rotated boxes
		send_beat(make_beat(MODE_LOAD, 5000, -7000, DIAG, -DIAG, DIAG, DIAG, 300, 40));
		send_beat(make_beat(MODE_TEST, 5000, -7000, DIAG, -DIAG, DIAG, DIAG, 300, 40));
		hold_off(20);

		ref_cx    = 5000;
		ref_cy    = -7000;
		ref_reach = 340;

		// rotated boxes around the reference, with new references and noise
		for (int i = 0; i < RAND_BEATS; i++) begin
			maybe_idle(i >= 300 && i < 500);
			pick = $urandom_range(99);
			h1   = pick_half();
			h2   = pick_half();
			if (pick < 10) begin
				ref_cx    = $signed($urandom_range(1 << 22)) - (1 << 21);
				ref_cy    = $signed($urandom_range(1 << 22)) - (1 << 21);
				ref_reach = h1 + h2;
				b = rotated_box(MODE_LOAD, ref_cx, ref_cy, h1, h2);
			end else if (pick < 22) begin
				b = noise_beat();
			end else begin
				span = ref_reach + h1 + h2 + 1;
				b = rotated_box(MODE_TEST,
					ref_cx + $signed($urandom_range(2 * span)) - span,
					ref_cy + $signed($urandom_range(2 * span)) - span, h1, h2);
			end
			send_beat(b);
		end
		start = 1'b0;

		// drain, then let a late strobe show up
		while (pending_results != 0) @(negedge clk);
		repeat (64) @(negedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
